>>> design/bdu_pkg.sv
// Package for the byte order mark detecting UTF-16 to UTF-8 unit.
// Holds the mode codes, the mark bytes and the result group type used by the design modules.
// No dependencies.
package bdu_pkg;

  // Stream mode codes
  localparam logic [2:0] MODE_DETECT = 3'd0;
  localparam logic [2:0] MODE_PASS   = 3'd1;
  localparam logic [2:0] MODE_LE     = 3'd2;
  localparam logic [2:0] MODE_BE     = 3'd3;
  localparam logic [2:0] MODE_STOP   = 3'd4;

  // Byte order mark bytes
  localparam logic [7:0] BOM_EF = 8'hEF;
  localparam logic [7:0] BOM_BB = 8'hBB;
  localparam logic [7:0] BOM_BF = 8'hBF;
  localparam logic [7:0] BOM_FF = 8'hFF;
  localparam logic [7:0] BOM_FE = 8'hFE;

  // Results caused by one request: up to three bytes, sent from entry 0 up
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      num;   // 0 means no result
    logic            bv;    // 0 for a bare end marker
    logic            fin;   // group closes the file
  } grp_t;

endpackage

>>> design/bdu_decode.sv
// Mode tracking and transcoding of one registered input byte into a result group.
// Holds mode, held bytes and held count. Depends on bdu_pkg.
module bdu_decode (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  output bdu_pkg::grp_t grp_o
);
  import bdu_pkg::*;

  logic [2:0]  mode_q, mode_d;
  logic [1:0]  hcnt_q, hcnt_d;
  logic [7:0]  h0_q, h0_d, h1_q, h1_d;
  logic [15:0] unit;

  // Code unit formed from the held byte and the current byte
  assign unit = (mode_q == MODE_LE) ? {byte_i, h0_q} : {h0_q, byte_i};

  // Next state and results
  always_comb begin
    mode_d = mode_q;
    hcnt_d = hcnt_q;
    h0_d   = h0_q;
    h1_d   = h1_q;
    grp_o  = '0;
    grp_o.bv = 1'b1;
    unique case (mode_q)
      MODE_DETECT: begin
        case (hcnt_q)
          2'd0: begin
            if (!last_i && (byte_i == BOM_EF || byte_i == BOM_FF || byte_i == BOM_FE)) begin
              h0_d   = byte_i;
              hcnt_d = 2'd1;
            end else begin
              mode_d         = MODE_PASS;
              grp_o.bytes[0] = byte_i;
              grp_o.num      = 2'd1;
            end
          end
          2'd1: begin
            if (h0_q == BOM_FF && byte_i == BOM_FE) begin
              mode_d = MODE_LE;
              hcnt_d = 2'd0;
            end else if (h0_q == BOM_FE && byte_i == BOM_FF) begin
              mode_d = MODE_BE;
              hcnt_d = 2'd0;
            end else if (h0_q == BOM_EF && byte_i == BOM_BB && !last_i) begin
              h1_d   = byte_i;
              hcnt_d = 2'd2;
            end else begin
              mode_d         = MODE_PASS;
              hcnt_d         = 2'd0;
              grp_o.bytes[0] = h0_q;
              grp_o.bytes[1] = byte_i;
              grp_o.num      = 2'd2;
            end
          end
          default: begin
            mode_d = MODE_PASS;
            hcnt_d = 2'd0;
            if (!(h0_q == BOM_EF && h1_q == BOM_BB && byte_i == BOM_BF)) begin
              grp_o.bytes[0] = h0_q;
              grp_o.bytes[1] = h1_q;
              grp_o.bytes[2] = byte_i;
              grp_o.num      = 2'd3;
            end
          end
        endcase
      end
      MODE_PASS: begin
        grp_o.bytes[0] = byte_i;
        grp_o.num      = 2'd1;
      end
      MODE_LE, MODE_BE: begin
        if (hcnt_q == 2'd0) begin
          h0_d   = byte_i;
          hcnt_d = 2'd1;
        end else begin
          hcnt_d = 2'd0;
          if (unit == 16'h0000) begin
            mode_d = MODE_STOP;
          end else if (unit < 16'h0080) begin
            grp_o.bytes[0] = unit[7:0];
            grp_o.num      = 2'd1;
          end else if (unit < 16'h0800) begin
            grp_o.bytes[0] = {3'b110, unit[10:6]};
            grp_o.bytes[1] = {2'b10, unit[5:0]};
            grp_o.num      = 2'd2;
          end else begin
            grp_o.bytes[0] = {4'b1110, unit[15:12]};
            grp_o.bytes[1] = {2'b10, unit[11:6]};
            grp_o.bytes[2] = {2'b10, unit[5:0]};
            grp_o.num      = 2'd3;
          end
        end
      end
      default: ;  // stopped: no results
    endcase
    // End of file: bare marker when nothing else, then back to detection
    if (last_i) begin
      grp_o.fin = 1'b1;
      mode_d    = MODE_DETECT;
      hcnt_d    = 2'd0;
      if (grp_o.num == 2'd0) begin
        grp_o.num = 2'd1;
        grp_o.bv  = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_DETECT;
      hcnt_q <= 2'd0;
    end else if (adv_i) begin
      mode_q <= mode_d;
      hcnt_q <= hcnt_d;
    end
  end

  // Held bytes, read only where the held count covers them
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      h0_q <= h0_d;
      h1_q <= h1_d;
    end
  end

endmodule

>>> design/bdu_emit.sv
// Result register: holds one result group and sends its bytes one per cycle while out_stall is low.
// Depends on bdu_pkg.
module bdu_emit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  bdu_pkg::grp_t grp_i,
  output logic          free_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    out_byte_o,
  output logic          byte_valid_o,
  output logic          run_last_o,
  output logic          stream_end_o
);
  import bdu_pkg::*;

  logic            valid_q;
  logic [1:0]      left_q;
  logic [2:0][7:0] bytes_q;
  logic            bv_q, fin_q;
  logic            pop;

  assign pop    = valid_q && !out_stall_i;
  assign free_o = !valid_q || (pop && left_q == 2'd1);

  // Control: remaining result count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      left_q  <= 2'd0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      left_q  <= grp_i.num;
    end else if (pop) begin
      valid_q <= (left_q != 2'd1);
      left_q  <= left_q - 2'd1;
    end
  end

  // Payload: shift down after each result is taken
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= grp_i.bytes;
      bv_q    <= grp_i.bv;
      fin_q   <= grp_i.fin;
    end else if (pop) begin
      bytes_q <= {8'h00, bytes_q[2], bytes_q[1]};
    end
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = bytes_q[0];
  assign byte_valid_o = bv_q;
  assign run_last_o   = (left_q == 2'd1);
  assign stream_end_o = (left_q == 2'd1) && fin_q;

endmodule

>>> design/bom_detect_utf16_to_utf8_unit.sv
// Top level of the byte order mark detecting UTF-16 to UTF-8 unit.
// Input register, bdu_decode and bdu_emit. Depends on bdu_pkg.
//
//   channel | direction | handshake          | payload
//   in      | request   | in_valid/in_stall   | in_byte, in_last
//   out     | result    | out_valid/out_stall | out_byte, byte_valid, run_last, stream_end
//
// A request moves from the input register through bdu_decode into the result register;
// its first result is on the result port once the result register holds it.
// Each request gives 0 to 3 results at one per cycle on the result port while out_stall
// is low; a request with no result leaves the input register without waiting for them.
// Reset returns the unit to mark detection with both registers empty.
// A stall on the result port backs up into the input register and then in_stall.
module bom_detect_utf16_to_utf8_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       run_last_o,
  output logic       stream_end_o
);
  import bdu_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       adv, free;
  grp_t       grp;

  // A request with no result leaves without waiting for the result register
  assign adv        = in_valid_q && (grp.num == 2'd0 || free);
  assign in_stall_o = in_valid_q && !adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
  end

  bdu_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .grp_o  (grp)
  );

  bdu_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (adv && grp.num != 2'd0),
    .grp_i        (grp),
    .free_o       (free),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .run_last_o   (run_last_o),
    .stream_end_o (stream_end_o)
  );

endmodule

>>> design/bdu_checker.sv
// Port-level checks for bom_detect_utf16_to_utf8_unit, bound to the top level.
// No dependencies.
module bdu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       byte_valid_o,
  input logic       run_last_o,
  input logic       stream_end_o
);

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(run_last_o) && $stable(stream_end_o))
    else $error("stalled result changed");

  // End of file closes a request's results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stream_end_o |-> run_last_o)
    else $error("stream_end without run_last");

  // Bare marker only at end of file, with zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> run_last_o && stream_end_o && out_byte_o == 8'h00)
    else $error("bad bare end marker");

  // Results of one request all carry data or none do
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !run_last_o |=> out_valid_o && byte_valid_o)
    else $error("request results broken up");

endmodule

bind bom_detect_utf16_to_utf8_unit bdu_checker u_bdu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_byte_o   (out_byte_o),
  .byte_valid_o (byte_valid_o),
  .run_last_o   (run_last_o),
  .stream_end_o (stream_end_o)
);

>>> verif/bom_detect_utf16_to_utf8_unit_test.sv
// Testbench for bom_detect_utf16_to_utf8_unit: directed and random files, with a
// scoreboard class that predicts the UTF-8 results of every accepted request.
// Depends on bdu_pkg and the unit itself.
`timescale 1ns / 100ps

module bom_detect_utf16_to_utf8_unit_test;
  import bdu_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_ITEMS = 500;

  // Predicts and checks the UTF-8 output stream of the unit
  class utf8_scoreboard;
    typedef struct packed {
      logic [7:0] data;
      logic       bv;
      logic       rlast;
      logic       fin;
    } utf8_res_t;

    utf8_res_t   pending_utf8_q[$];
    utf8_res_t   run_q[$];
    logic [2:0]  mode;
    logic [7:0]  held [2];
    logic [1:0]  held_cnt;
    logic        stopped;
    int unsigned errors;

    function new();
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      mode     = MODE_DETECT;
      held[0]  = 8'h00;
      held[1]  = 8'h00;
      held_cnt = 2'd0;
      stopped  = 1'b0;
    endfunction

    function void put_byte(logic [7:0] b);
      utf8_res_t r;
      r = '{data: b, bv: 1'b1, rlast: 1'b0, fin: 1'b0};
      run_q.push_back(r);
    endfunction

    // One 16-bit code unit as 1 to 3 UTF-8 bytes; surrogates stay unpaired
    function void put_unit(logic [15:0] u);
      if (u < 16'h0080) begin
        put_byte(u[7:0]);
      end else if (u < 16'h0800) begin
        put_byte({3'b110, u[10:6]});
        put_byte({2'b10, u[5:0]});
      end else begin
        put_byte({4'b1110, u[15:12]});
        put_byte({2'b10, u[11:6]});
        put_byte({2'b10, u[5:0]});
      end
    endfunction

    // Mark detection over the leading bytes of a file
    function void detect_mark(logic [7:0] b, logic last);
      if (held_cnt == 2'd0) begin
        if (!last && (b == BOM_EF || b == BOM_FF || b == BOM_FE)) begin
          held[0]  = b;
          held_cnt = 2'd1;
        end else begin
          mode = MODE_PASS;
          put_byte(b);
        end
      end else if (held_cnt == 2'd1) begin
        if (held[0] == BOM_FF && b == BOM_FE) begin
          mode     = MODE_LE;
          held_cnt = 2'd0;
        end else if (held[0] == BOM_FE && b == BOM_FF) begin
          mode     = MODE_BE;
          held_cnt = 2'd0;
        end else if (held[0] == BOM_EF && b == BOM_BB && !last) begin
          held[1]  = b;
          held_cnt = 2'd2;
        end else begin
          mode     = MODE_PASS;
          held_cnt = 2'd0;
          put_byte(held[0]);
          put_byte(b);
        end
      end else begin
        mode     = MODE_PASS;
        held_cnt = 2'd0;
        if (!(held[0] == BOM_EF && held[1] == BOM_BB && b == BOM_BF)) begin
          put_byte(held[0]);
          put_byte(held[1]);
          put_byte(b);
        end
      end
    endfunction

    // Pairs bytes into code units; a zero unit stops the file
    function void pair_unit(logic [7:0] b);
      logic [15:0] u;
      if (held_cnt == 2'd0) begin
        held[0]  = b;
        held_cnt = 2'd1;
      end else begin
        held_cnt = 2'd0;
        u = (mode == MODE_LE) ? {b, held[0]} : {held[0], b};
        if (u == 16'h0000) begin
          mode    = MODE_STOP;
          stopped = 1'b1;
        end else begin
          put_unit(u);
        end
      end
    endfunction

    // Expected results of one accepted request
    function void transcode(logic [7:0] b, logic last);
      utf8_res_t r;
      run_q.delete();
      if (!stopped) begin
        case (mode)
          MODE_DETECT:      detect_mark(b, last);
          MODE_LE, MODE_BE: pair_unit(b);
          MODE_PASS:        put_byte(b);
          default:          ;
        endcase
      end
      // bare end marker when the last byte gives no data
      if (run_q.size() == 0 && last) begin
        r = '{data: 8'h00, bv: 1'b0, rlast: 1'b0, fin: 1'b0};
        run_q.push_back(r);
      end
      if (run_q.size() > 0) begin
        r = run_q[run_q.size() - 1];
        r.rlast = 1'b1;
        r.fin   = last;
        run_q[run_q.size() - 1] = r;
      end
      foreach (run_q[i]) pending_utf8_q.push_back(run_q[i]);
      if (last) clear_state();
    endfunction

    function void note_request(logic [7:0] b, logic last);
      transcode(b, last);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [7:0] data, logic bv, logic rlast, logic fin);
      utf8_res_t want;
      if (pending_utf8_q.size() == 0) begin
        report($sformatf("unexpected result byte %02h bv %b", data, bv));
        return;
      end
      want = pending_utf8_q.pop_front();
      if (want.bv != bv)
        report($sformatf("byte_valid %b, want %b", bv, want.bv));
      if (want.data != data)
        report($sformatf("out_byte %02h, want %02h", data, want.data));
      if (want.rlast != rlast)
        report($sformatf("run_last %b, want %b (byte %02h)", rlast, want.rlast, want.data));
      if (want.fin != fin)
        report($sformatf("stream_end %b, want %b (byte %02h)", fin, want.fin, want.data));
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i    = 8'h00;
  logic       in_last_i    = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i  = 1'b0;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic       run_last_o;
  logic       stream_end_o;

  utf8_scoreboard utf8_sb = new();
  int unsigned    send_idle_pct = 18;
  int unsigned    recv_idle_pct = 67;
  int unsigned    req_cnt       = 0;
  int unsigned    cycle_cnt     = 0;
  logic [7:0]     file_q[$];

  bom_detect_utf16_to_utf8_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .run_last_o   (run_last_o),
    .stream_end_o (stream_end_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Receiver stalls at random
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      utf8_sb.check_result(out_byte_o, byte_valid_o, run_last_o, stream_end_o);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // One request; valid only drops when the sender takes a gap
  task automatic send_req(logic [7:0] b, logic last);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    utf8_sb.note_request(b, last);
    req_cnt++;
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_req(file_q[i], i == file_q.size() - 1);
  endtask

  function automatic logic [15:0] rand_unit();
    logic [15:0] u;
    case ($urandom_range(0, 5))
      0:       u = 16'($urandom_range(1, 16'h007F));
      1:       u = 16'($urandom_range(16'h0080, 16'h07FF));
      2:       u = 16'($urandom_range(16'h0800, 16'hFFFF));
      3:       u = 16'($urandom_range(16'hD800, 16'hDFFF));
      4:       u = 16'($urandom_range(0, 16'hFFFF));
      default: begin
        case ($urandom_range(0, 5))
          0:       u = 16'h0001;
          1:       u = 16'h007F;
          2:       u = 16'h0080;
          3:       u = 16'h07FF;
          4:       u = 16'h0800;
          default: u = 16'hFFFF;
        endcase
      end
    endcase
    // rare zero unit ends the output early
    if ($urandom_range(0, 15) == 0) u = 16'h0000;
    return u;
  endfunction

  // Random file: marked UTF-16 or marked UTF-8, unmarked bytes, some broken marks and noise
  task automatic build_file();
    int unsigned kind;
    int unsigned len;
    logic [15:0] u;
    kind = $urandom_range(0, 9);
    len  = $urandom_range(0, 8);
    file_q.delete();
    case (kind)
      0, 1, 2, 3, 4: begin
        if (kind < 3) file_q = '{BOM_FF, BOM_FE};
        else          file_q = '{BOM_FE, BOM_FF};
        repeat (len) begin
          u = rand_unit();
          if (kind < 3) begin
            file_q.push_back(u[7:0]);
            file_q.push_back(u[15:8]);
          end else begin
            file_q.push_back(u[15:8]);
            file_q.push_back(u[7:0]);
          end
        end
        // odd trailing byte
        if ($urandom_range(0, 3) == 0) file_q.push_back(8'($urandom_range(0, 255)));
      end
      5: begin
        file_q = '{BOM_EF, BOM_BB, BOM_BF};
        repeat (len) file_q.push_back(8'($urandom_range(0, 255)));
      end
      6: begin
        file_q.push_back(8'($urandom_range(0, 8'h7F)));
        repeat (len) file_q.push_back(8'($urandom_range(0, 255)));
      end
      7: begin
        // broken or partial marks
        case ($urandom_range(0, 4))
          0:       file_q = '{BOM_EF};
          1:       file_q = '{BOM_EF, BOM_BB};
          2:       file_q = '{BOM_EF, BOM_BB, 8'($urandom_range(0, 255))};
          3:       file_q = '{BOM_FF, 8'($urandom_range(0, 255))};
          default: file_q = '{BOM_FE, 8'($urandom_range(0, 255))};
        endcase
        repeat (len) file_q.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        repeat ($urandom_range(1, 10)) file_q.push_back(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  initial begin
    int unsigned target;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: LE with 1/2/3-byte units, zero unit stop, then a byte after the stop
    file_q = '{BOM_FF, BOM_FE, 8'h7F, 8'h00, 8'h80, 8'h00, 8'hFF, 8'hFF,
               8'h00, 8'h00, 8'h12};
    send_file();
    // BE with 07FF, a surrogate and an odd trailing byte
    file_q = '{BOM_FE, BOM_FF, 8'h07, 8'hFF, 8'hD8, 8'h00, 8'h41};
    send_file();
    // UTF-8 mark only
    file_q = '{BOM_EF, BOM_BB, BOM_BF};
    send_file();
    // file ends during detection
    file_q = '{BOM_EF, BOM_BB};
    send_file();
    file_q = '{BOM_FE};
    send_file();
    // no mark, zero byte passes through
    file_q = '{8'h00, 8'hFF};
    send_file();

    // Random in three idling phases
    for (int p = 0; p < 3; p++) begin
      case (p)
        0:       begin send_idle_pct = 18; recv_idle_pct = 67; end
        1:       begin send_idle_pct = 67; recv_idle_pct = 18; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      target = req_cnt + RANDOM_ITEMS / 3;
      while (req_cnt < target) begin
        build_file();
        send_file();
      end
    end
    in_valid_i <= 1'b0;

    // drain, then watch for stray results
    while (utf8_sb.pending_utf8_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (utf8_sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
